FILE: design/i2cbb_pkg.sv
`default_nettype none
package i2cbb_pkg;

  // Item kinds on the input channel
  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_STOP  = 3'd1,
    KIND_SEND  = 3'd2,
    KIND_RECV  = 3'd3,
    KIND_SACK  = 3'd4,
    KIND_RACK  = 3'd5,
    KIND_TICK  = 3'd6
  } kind_t;

  localparam int unsigned STEP_W = 5;

  // Step counts per command
  localparam logic [STEP_W-1:0] LEN_START = 5'd4;
  localparam logic [STEP_W-1:0] LEN_STOP  = 5'd3;
  localparam logic [STEP_W-1:0] LEN_SEND  = 5'd24;
  localparam logic [STEP_W-1:0] LEN_RECV  = 5'd25;
  localparam logic [STEP_W-1:0] LEN_SACK  = 5'd3;
  localparam logic [STEP_W-1:0] LEN_RACK  = 5'd4;

  // Bit phase inside a send or receive bit slot
  typedef enum logic [1:0] {
    PH_DATA = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    kind_t             cmd;
    logic [STEP_W-1:0] step;
    phase_t            phase;
    logic [7:0]        shift;
    logic [7:0]        tx;
    logic              scl;
    logic              sda;
    logic              ack;
    logic              busy;
  } seq_state_t;

  function automatic logic [STEP_W-1:0] seq_len(kind_t k);
    logic [STEP_W-1:0] len;
    unique case (k)
      KIND_STOP: len = LEN_STOP;
      KIND_SEND: len = LEN_SEND;
      KIND_RECV: len = LEN_RECV;
      KIND_SACK: len = LEN_SACK;
      KIND_RACK: len = LEN_RACK;
      default:   len = LEN_START;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: design/i2cbb_if.sv
`default_nettype none
interface i2cbb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       ack_out;
  logic       sda_in;

  modport source (output valid, kind, tx_byte, ack_out, sda_in, input ready);
  modport sink   (input valid, kind, tx_byte, ack_out, sda_in, output ready);
endinterface

interface i2cbb_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_seen, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_seen, rejected, output ready);
endinterface
`default_nettype wire

FILE: design/i2c_bit_bang_master_core.sv
`default_nettype none
// Channel   Dir  Handshake           Payload
// in_ch     in   valid/ready         kind, tx_byte, ack_out, sda_in
// out_ch    out  valid/ready         scl_level, sda_level, busy_res, done_res,
//                                    rx_byte, ack_seen, rejected
//
// One item per cycle sustained while the output is not stalled; an item's result is
// registered (the step logic sits between the input and result registers).
// While a result waits downstream the input register can still take one item.
// Synchronous active-low reset: both pins released, sequencer idle.
// A stalled output holds the result and the state update waits with it.
module i2c_bit_bang_master_core (
  input wire logic  clk,
  input wire logic  rst_n,
  i2cbb_in_if.sink  in_ch,
  i2cbb_out_if.source out_ch
);
  import i2cbb_pkg::*;

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  out_item_t  res_nxt;
  in_item_t   in_item;
  logic       move;

  assign in_item = '{kind: in_ch.kind, tx_byte: in_ch.tx_byte,
                     ack_out: in_ch.ack_out, sda_in: in_ch.sda_in};

  // Item leaves the input register when the result register is free
  assign move        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || move;

  i2cbb_step u_step (
    .cur  (state_r),
    .item (in_item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r <= in_item;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{cmd: KIND_START, step: '0, phase: PH_DATA, shift: '0, tx: '0,
                   scl: 1'b1, sda: 1'b1, ack: 1'b0, busy: 1'b0};
    end else if (move) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_level = out_item_r.scl_level;
  assign out_ch.sda_level = out_item_r.sda_level;
  assign out_ch.busy_res  = out_item_r.busy_res;
  assign out_ch.done_res  = out_item_r.done_res;
  assign out_ch.rx_byte   = out_item_r.rx_byte;
  assign out_ch.ack_seen  = out_item_r.ack_seen;
  assign out_ch.rejected  = out_item_r.rejected;

endmodule
`default_nettype wire

FILE: design/i2cbb_step.sv
`default_nettype none
module i2cbb_step (
  input  wire i2cbb_pkg::seq_state_t cur,
  input  wire i2cbb_pkg::in_item_t   item,
  output i2cbb_pkg::seq_state_t nxt,
  output i2cbb_pkg::out_item_t  res
);
  import i2cbb_pkg::*;

  logic              done;
  logic              rej;
  logic [STEP_W-1:0] step_inc;
  phase_t            phase_adv;

  // Next phase in the three-step bit slot
  always_comb begin
    unique case (cur.phase)
      PH_DATA: phase_adv = PH_HIGH;
      PH_HIGH: phase_adv = PH_LOW;
      default: phase_adv = PH_DATA;
    endcase
  end

  assign step_inc = cur.step + 5'd1;

  // One item against the sequencer state
  always_comb begin
    nxt  = cur;
    done = 1'b0;
    rej  = 1'b0;
    if (item.kind <= 3'(KIND_RACK)) begin
      if (cur.busy) begin
        rej = 1'b1;
      end else begin
        nxt.cmd   = kind_t'(item.kind);
        nxt.step  = '0;
        nxt.phase = PH_DATA;
        nxt.busy  = 1'b1;
        if (item.kind == 3'(KIND_SEND)) begin
          nxt.tx = item.tx_byte;
        end else if (item.kind == 3'(KIND_SACK)) begin
          nxt.tx = {item.ack_out, 7'd0};
        end
      end
    end else if (item.kind == 3'(KIND_TICK) && cur.busy) begin
      unique case (cur.cmd)
        KIND_START: begin
          unique case (cur.step[1:0])
            2'd0:    nxt.sda = 1'b1;
            2'd1:    nxt.scl = 1'b1;
            2'd2:    nxt.sda = 1'b0;
            default: nxt.scl = 1'b0;
          endcase
        end
        KIND_STOP: begin
          unique case (cur.step[1:0])
            2'd0:    nxt.sda = 1'b0;
            2'd1:    nxt.scl = 1'b1;
            default: nxt.sda = 1'b1;
          endcase
        end
        KIND_SEND: begin
          // data bit leaves from the top of the transmit shifter
          nxt.phase = phase_adv;
          unique case (cur.phase)
            PH_DATA: nxt.sda = cur.tx[7];
            PH_HIGH: nxt.scl = 1'b1;
            default: begin
              nxt.scl = 1'b0;
              nxt.tx  = {cur.tx[6:0], 1'b0};
            end
          endcase
        end
        KIND_RECV: begin
          if (cur.step == '0) begin
            nxt.sda   = 1'b1;
            nxt.shift = '0;
          end else begin
            nxt.phase = phase_adv;
            unique case (cur.phase)
              PH_DATA: nxt.scl   = 1'b1;
              PH_HIGH: nxt.shift = {cur.shift[6:0], item.sda_in};
              default: nxt.scl   = 1'b0;
            endcase
          end
        end
        KIND_SACK: begin
          unique case (cur.step[1:0])
            2'd0:    nxt.sda = cur.tx[7];
            2'd1:    nxt.scl = 1'b1;
            default: nxt.scl = 1'b0;
          endcase
        end
        default: begin
          // receive ack
          unique case (cur.step[1:0])
            2'd0:    nxt.sda = 1'b1;
            2'd1:    nxt.scl = 1'b1;
            2'd2:    nxt.ack = item.sda_in;
            default: nxt.scl = 1'b0;
          endcase
        end
      endcase
      nxt.step = step_inc;
      if (step_inc >= seq_len(cur.cmd)) begin
        done     = 1'b1;
        nxt.busy = 1'b0;
        nxt.step = '0;
      end
    end
  end

  // Result reflects the state after this item
  always_comb begin
    res.scl_level = nxt.scl;
    res.sda_level = nxt.sda;
    res.busy_res  = nxt.busy;
    res.done_res  = done;
    res.rx_byte   = nxt.shift;
    res.ack_seen  = nxt.ack;
    res.rejected  = rej;
  end

endmodule
`default_nettype wire

FILE: verif/i2cbb_checker.sv
`timescale 1ns / 100ps
module i2cbb_checker (
  input wire logic clk,
  input wire logic rst_n,
  i2cbb_in_if      in_ch,
  i2cbb_out_if     out_ch,
  output int       fail_count,
  output int       pending
);
  import i2cbb_pkg::*;

  // Shadow copy of the sequencer
  kind_t      cmd_q;
  logic [4:0] step_q;
  logic [7:0] shift_q;
  logic [7:0] tx_q;
  logic       scl_q;
  logic       sda_q;
  logic       ack_q;
  logic       busy_q;

  out_item_t  pin_states[$];
  int         mismatches;

  // Apply one item to the shadow sequencer and give the pin/flag snapshot after it
  task automatic step_sequencer(input in_item_t it, output out_item_t res);
    logic [4:0] s;
    logic [4:0] len;
    res.rejected = 1'b0;
    res.done_res = 1'b0;
    if (it.kind <= KIND_RACK) begin
      if (busy_q) begin
        res.rejected = 1'b1;
      end else begin
        cmd_q  = kind_t'(it.kind);
        step_q = '0;
        busy_q = 1'b1;
        if (cmd_q == KIND_SEND) tx_q = it.tx_byte;
        else if (cmd_q == KIND_SACK) tx_q = {7'd0, it.ack_out};
      end
    end else if (it.kind == KIND_TICK && busy_q) begin
      s = step_q;
      case (cmd_q)
        KIND_START: begin
          case (s)
            5'd0:    sda_q = 1'b1;
            5'd1:    scl_q = 1'b1;
            5'd2:    sda_q = 1'b0;
            default: scl_q = 1'b0;
          endcase
          len = LEN_START;
        end
        KIND_STOP: begin
          case (s)
            5'd0:    sda_q = 1'b0;
            5'd1:    scl_q = 1'b1;
            default: sda_q = 1'b1;
          endcase
          len = LEN_STOP;
        end
        KIND_SEND: begin
          // three steps per bit, MSB first
          case (phase_t'(s % 3))
            PH_DATA: sda_q = tx_q[7 - s / 3];
            PH_HIGH: scl_q = 1'b1;
            default: scl_q = 1'b0;
          endcase
          len = LEN_SEND;
        end
        KIND_RECV: begin
          // release SDA first, then three steps per sampled bit
          if (s == 5'd0) begin
            sda_q   = 1'b1;
            shift_q = '0;
          end else begin
            case (phase_t'((s - 5'd1) % 3))
              PH_DATA: scl_q = 1'b1;
              PH_HIGH: shift_q = {shift_q[6:0], it.sda_in};
              default: scl_q = 1'b0;
            endcase
          end
          len = LEN_RECV;
        end
        KIND_SACK: begin
          case (s)
            5'd0:    sda_q = tx_q[0];
            5'd1:    scl_q = 1'b1;
            default: scl_q = 1'b0;
          endcase
          len = LEN_SACK;
        end
        default: begin
          case (s)
            5'd0:    sda_q = 1'b1;
            5'd1:    scl_q = 1'b1;
            5'd2:    ack_q = it.sda_in;
            default: scl_q = 1'b0;
          endcase
          len = LEN_RACK;
        end
      endcase
      step_q = step_q + 5'd1;
      if (step_q >= len) begin
        res.done_res = 1'b1;
        busy_q       = 1'b0;
        step_q       = '0;
      end
    end
    res.scl_level = scl_q;
    res.sda_level = sda_q;
    res.busy_res  = busy_q;
    res.rx_byte   = shift_q;
    res.ack_seen  = ack_q;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Track accepted items and compare results in order
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    in_item_t  it;
    if (!rst_n) begin
      cmd_q   = KIND_START;
      step_q  = '0;
      shift_q = '0;
      tx_q    = '0;
      scl_q   = 1'b1;
      sda_q   = 1'b1;
      ack_q   = 1'b0;
      busy_q  = 1'b0;
      pin_states.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.scl_level, out_ch.sda_level, out_ch.busy_res, out_ch.done_res,
               out_ch.rx_byte, out_ch.ack_seen, out_ch.rejected};
        if (pin_states.size() == 0) begin
          $error("result item with nothing outstanding");
          mismatches++;
        end else begin
          want = pin_states.pop_front();
          compare_field("scl_level", want.scl_level, got.scl_level);
          compare_field("sda_level", want.sda_level, got.sda_level);
          compare_field("busy_res",  want.busy_res,  got.busy_res);
          compare_field("done_res",  want.done_res,  got.done_res);
          compare_field("rx_byte",   want.rx_byte,   got.rx_byte);
          compare_field("ack_seen",  want.ack_seen,  got.ack_seen);
          compare_field("rejected",  want.rejected,  got.rejected);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it = {in_ch.kind, in_ch.tx_byte, in_ch.ack_out, in_ch.sda_in};
        step_sequencer(it, want);
        pin_states.push_back(want);
      end
    end
    fail_count <= mismatches;
    pending    <= pin_states.size();
  end

endmodule

FILE: verif/i2c_bit_bang_master_core_test.sv
`timescale 1ns / 100ps
module i2c_bit_bang_master_core_test;
  import i2cbb_pkg::*;

  localparam int RANDOM_ITEMS = 680;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_FROM    = 500;
  localparam int HOLD_TO      = 650;

  // Kind code with no meaning; the block ignores it
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  int   sent;
  bit   calm;

  i2cbb_in_if  in_ch ();
  i2cbb_out_if out_ch ();

  i2c_bit_bang_master_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  i2cbb_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, one long hold-off, calm stretch
  always @(posedge clk) begin
    int rx_cycles;
    rx_cycles++;
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (rx_cycles >= HOLD_FROM && rx_cycles < HOLD_TO) out_ch.ready <= 1'b0;
    else if (calm) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= 34);
  end

  // Offer one item, with an occasional gap before it; returns at the accepting edge
  task automatic offer(input logic [2:0] k, input logic [7:0] tb, input logic ao,
                       input logic si);
    int gap;
    if (!calm && $urandom_range(99) < 34) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.tx_byte <= tb;
    in_ch.ack_out <= ao;
    in_ch.sda_in  <= si;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // A command then n ticks; sda pattern gives the pin level per tick.
  // With noise, stray commands and unused kinds land mid-sequence.
  task automatic run_command(input kind_t k, input logic [7:0] tb, input logic ao,
                             input logic [31:0] sda_pat, input int n_ticks,
                             input bit noisy);
    logic [2:0] stray;
    offer(k, tb, ao, 1'($urandom));
    for (int i = 0; i < n_ticks; i++) begin
      if (noisy && $urandom_range(99) < 8) begin
        stray = 3'($urandom);
        if (stray == KIND_TICK) stray = KIND_STOP;
        offer(stray, 8'($urandom), 1'($urandom), 1'($urandom));
      end
      offer(KIND_TICK, 8'($urandom), 1'($urandom), sda_pat[i]);
    end
  endtask

  initial begin
    int    ticks_of[6];
    int    goal;
    int    n;
    kind_t k;
    ticks_of = '{int'(LEN_START), int'(LEN_STOP), int'(LEN_SEND), int'(LEN_RECV),
                 int'(LEN_SACK), int'(LEN_RACK)};
    rst_n         = 1'b0;
    calm          = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = KIND_TICK;
    in_ch.tx_byte = '0;
    in_ch.ack_out = 1'b0;
    in_ch.sda_in  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, unused kind, busy rejection, every command
    offer(KIND_TICK, 8'h00, 1'b0, 1'b0);
    offer(KIND_UNUSED, 8'hFF, 1'b1, 1'b1);
    offer(KIND_START, 8'h00, 1'b0, 1'b0);
    offer(KIND_STOP, 8'hFF, 1'b1, 1'b1);
    offer(KIND_UNUSED, 8'h00, 1'b0, 1'b0);
    run_command(KIND_SEND, 8'hFF, 1'b0, '0, 0, 1'b0);
    repeat (LEN_START) offer(KIND_TICK, 8'h00, 1'b0, 1'b1);
    run_command(KIND_SEND, 8'hFF, 1'b1, '1, LEN_SEND, 1'b0);
    run_command(KIND_RECV, 8'h00, 1'b0, '1, LEN_RECV, 1'b0);
    run_command(KIND_SACK, 8'h00, 1'b1, '0, LEN_SACK, 1'b0);
    run_command(KIND_RACK, 8'h00, 1'b0, '0, LEN_RACK, 1'b0);
    run_command(KIND_STOP, 8'h00, 1'b0, '0, LEN_STOP, 1'b0);

    // Random: mostly whole command sequences, some broken ones and loose items
    goal = sent + RANDOM_ITEMS;
    while (sent < goal) begin
      calm = (goal - sent < 450) && (goal - sent >= 300);
      k = kind_t'($urandom_range(KIND_START, KIND_RACK));
      if ($urandom_range(99) < 85) begin
        run_command(k, 8'($urandom), 1'($urandom), $urandom, ticks_of[k], 1'b1);
        if ($urandom_range(9) == 0) begin
          n = $urandom_range(1, 3);
          repeat (n) offer(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
        end
      end else if ($urandom_range(1) == 0) begin
        run_command(k, 8'($urandom), 1'($urandom), $urandom,
                    $urandom_range(0, ticks_of[k]), 1'b1);
      end else begin
        offer(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
    calm = 1'b0;

    // Drain
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
